FILE: src/ffba_pkg.sv
// ffba_pkg: shared types, codes and defaults for the first-fit block allocator.
// Used by ffba_cell and first_fit_block_allocator; depends on nothing.
package ffba_pkg;

	// fixed field widths of the request and response words
	localparam int SIZE_W  = 20;
	localparam int RES_W   = 20;
	localparam int LIMIT_W = 21;

	// parameter defaults
	localparam int MAX_BLOCKS_DEF   = 64;
	localparam int ADDR_BITS_DEF    = 20;
	localparam int HEADER_BYTES_DEF = 16;

	localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RESET = LIMIT_W'(1048576);

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOSPACE    = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_UNKNOWN    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_OUT
	} state_t;

	// request word
	typedef struct packed {
		mode_t             mode;
		logic [SIZE_W-1:0] request_size;
		logic [RES_W-1:0]  block_address;
	} req_t;

	// response word
	typedef struct packed {
		logic [RES_W-1:0] result_address;
		status_t          status;
		logic             reused;
	} rsp_t;

	// control part of the search token that walks the cell chain
	typedef struct packed {
		logic  valid;
		mode_t op;
		logic  hit;
		logic  last;
	} tok_ctl_t;

endpackage

FILE: src/ffba_cell.sv
// ffba_cell: one table entry of the allocator plus one stage of the search chain.
// Depends on ffba_pkg.
module ffba_cell #(
	parameter int ADDR_BITS    = 20,
	parameter int HEADER_BYTES = 16,
	parameter int IDX_W        = 6,
	parameter int CNT_W        = 7,
	parameter int INDEX        = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [CNT_W-1:0]         count,
	// token from the left neighbor
	input  ffba_pkg::tok_ctl_t       ctl_in,
	input  logic [ffba_pkg::SIZE_W-1:0] size_in,
	input  logic [ffba_pkg::RES_W-1:0]  addr_in,
	input  logic [ADDR_BITS-1:0]     off_in,
	// token to the right neighbor
	output ffba_pkg::tok_ctl_t       ctl_out,
	output logic [ffba_pkg::SIZE_W-1:0] size_out,
	output logic [ffba_pkg::RES_W-1:0]  addr_out,
	output logic [ADDR_BITS-1:0]     off_out,
	// append write from the controller
	input  logic                     wr_en,
	input  logic [IDX_W-1:0]         wr_idx,
	input  logic [ADDR_BITS-1:0]     wr_off,
	input  logic [ffba_pkg::SIZE_W-1:0] wr_size
);
	import ffba_pkg::*;

	localparam int CW = ((ADDR_BITS > RES_W) ? ADDR_BITS : RES_W) + 1;

	// entry contents, undefined until appended
	logic [ADDR_BITS-1:0] off_q;
	logic [SIZE_W-1:0]    size_q;
	logic                 free_q;

	tok_ctl_t             ctl_q;
	logic [SIZE_W-1:0]    size_tok_q;
	logic [RES_W-1:0]     addr_tok_q;
	logic [ADDR_BITS-1:0] off_tok_q;

	logic active, is_last, match_alloc, match_free, take, wr_hit;

	// match logic for this entry
	always_comb begin
		active      = CNT_W'(INDEX) < count;
		is_last     = CNT_W'(INDEX + 1) == count;
		match_alloc = (ctl_in.op == MODE_ALLOC) && free_q && (size_q >= size_in);
		match_free  = (ctl_in.op == MODE_FREE) &&
			((CW'(off_q) + CW'(HEADER_BYTES)) == CW'(addr_in));
		take        = ctl_in.valid && !ctl_in.hit && active && (match_alloc || match_free);
		wr_hit      = wr_en && (wr_idx == IDX_W'(INDEX));
	end

	// entry update: append write, or claim / release on a first match
	always_ff @(posedge clk) begin
		if (wr_hit) begin
			off_q  <= wr_off;
			size_q <= wr_size;
			free_q <= 1'b0;
		end else if (take) begin
			if (ctl_in.op == MODE_ALLOC) begin
				free_q <= 1'b0;
			end else if (!is_last) begin
				free_q <= 1'b1;
			end
		end
	end

	// token control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.valid <= ctl_in.valid;
			ctl_q.op    <= ctl_in.op;
			ctl_q.hit   <= ctl_in.hit | take;
			ctl_q.last  <= take ? is_last : ctl_in.last;
		end
	end

	// token payload
	always_ff @(posedge clk) begin
		size_tok_q <= size_in;
		addr_tok_q <= addr_in;
		off_tok_q  <= take ? off_q : off_in;
	end

	assign ctl_out  = ctl_q;
	assign size_out = size_tok_q;
	assign addr_out = addr_tok_q;
	assign off_out  = off_tok_q;

endmodule

FILE: src/first_fit_block_allocator.sv
// first_fit_block_allocator: controller and chain of ffba_cell table entries.
// Depends on ffba_pkg and ffba_cell.
//
// Usage:
//  Request channel (req_valid / req_stall / req) carries allocate or free words;
//  response channel (rsp_valid / rsp_stall / rsp) returns one word per request.
//  heap_limit is written through cfg_we / cfg_wdata; the user must do so only
//  while the block is idle, as the block itself does not enforce it.
//  One request is in flight at a time: req_stall is high from acceptance until
//  its response word has been taken. A zero-size allocate or a null free
//  answers without a search. Any other request sends a search token down the
//  row of MAX_BLOCKS cells, one cell per cycle, and the response word is
//  registered when the token leaves the last cell.
//  Appends go into the cell at count_q when the token leaves the chain.
//  Reset empties the table (count and break to zero) and sets heap_limit to
//  1048576; no clearing pass is needed. While rsp_stall is high the response
//  word holds and no new request is accepted.
module first_fit_block_allocator #(
	parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
	parameter int ADDR_BITS    = ffba_pkg::ADDR_BITS_DEF,
	parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ffba_pkg::LIMIT_W-1:0] cfg_wdata,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  ffba_pkg::req_t               req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output ffba_pkg::rsp_t               rsp
);
	import ffba_pkg::*;

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int BRK_W = ADDR_BITS + 1;
	localparam int SUM_W = ((BRK_W > LIMIT_W) ? BRK_W : LIMIT_W) + 2;
	localparam int CW    = ((ADDR_BITS > RES_W) ? ADDR_BITS : RES_W) + 1;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     count_q;
	logic [BRK_W-1:0]     brk_q;
	logic [LIMIT_W-1:0]   limit_q;
	req_t                 req_q;
	logic                 launch_q;
	rsp_t                 rsp_q;

	// chain links
	tok_ctl_t             link_ctl  [0:MAX_BLOCKS];
	logic [SIZE_W-1:0]    link_size [0:MAX_BLOCKS];
	logic [RES_W-1:0]     link_addr [0:MAX_BLOCKS];
	logic [ADDR_BITS-1:0] link_off  [0:MAX_BLOCKS];

	logic                 accept, immediate, done;
	logic                 table_full, fits, wr_en;
	logic [SUM_W-1:0]     sum, cap, lim_ext, eff_lim;
	logic [CW-1:0]        hit_payload, app_payload;
	tok_ctl_t             end_ctl;

	// token injection
	assign link_ctl[0]  = '{valid: launch_q, op: req_q.mode, hit: 1'b0, last: 1'b0};
	assign link_size[0] = req_q.request_size;
	assign link_addr[0] = req_q.block_address;
	assign link_off[0]  = '0;

	// row of table cells
	for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
		ffba_cell #(
			.ADDR_BITS    (ADDR_BITS),
			.HEADER_BYTES (HEADER_BYTES),
			.IDX_W        (IDX_W),
			.CNT_W        (CNT_W),
			.INDEX        (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.count    (count_q),
			.ctl_in   (link_ctl[i]),
			.size_in  (link_size[i]),
			.addr_in  (link_addr[i]),
			.off_in   (link_off[i]),
			.ctl_out  (link_ctl[i+1]),
			.size_out (link_size[i+1]),
			.addr_out (link_addr[i+1]),
			.off_out  (link_off[i+1]),
			.wr_en    (wr_en),
			.wr_idx   (count_q[IDX_W-1:0]),
			.wr_off   (brk_q[ADDR_BITS-1:0]),
			.wr_size  (req_q.request_size)
		);
	end

	// request decode and end-of-chain evaluation
	always_comb begin
		end_ctl     = link_ctl[MAX_BLOCKS];
		accept      = req_valid && (state_q == S_IDLE);
		immediate   = (req.mode == MODE_ALLOC) ? (req.request_size == '0)
			: (req.block_address == '0);
		done        = (state_q == S_WALK) && end_ctl.valid;
		table_full  = count_q >= CNT_W'(MAX_BLOCKS);
		sum         = SUM_W'(brk_q) + SUM_W'(HEADER_BYTES) + SUM_W'(req_q.request_size);
		cap         = SUM_W'(1) << ADDR_BITS;
		lim_ext     = SUM_W'(limit_q);
		eff_lim     = (lim_ext > cap) ? cap : lim_ext;
		fits        = sum <= eff_lim;
		wr_en       = done && (end_ctl.op == MODE_ALLOC) && !end_ctl.hit && !table_full && fits;
		hit_payload = CW'(link_off[MAX_BLOCKS]) + CW'(HEADER_BYTES);
		app_payload = CW'(brk_q[ADDR_BITS-1:0]) + CW'(HEADER_BYTES);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = immediate ? S_OUT : S_WALK;
				end
			end
			S_WALK: begin
				if (end_ctl.valid) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		req_stall = (state_q != S_IDLE);
		rsp_valid = (state_q == S_OUT);
	end

	assign rsp = rsp_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			brk_q    <= '0;
			limit_q  <= HEAP_LIMIT_RESET;
			launch_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			launch_q <= accept && !immediate;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (done) begin
				if (end_ctl.op == MODE_FREE) begin
					if (end_ctl.hit && end_ctl.last) begin
						count_q <= count_q - CNT_W'(1);
						brk_q   <= BRK_W'(link_off[MAX_BLOCKS]);
					end
				end else if (wr_en) begin
					count_q <= count_q + CNT_W'(1);
					brk_q   <= sum[BRK_W-1:0];
				end
			end
		end
	end

	// request hold and response word
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			if (immediate) begin
				rsp_q.result_address <= '0;
				rsp_q.status         <= (req.mode == MODE_ALLOC) ? ST_NOSPACE : ST_OK;
				rsp_q.reused         <= 1'b0;
			end
		end
		if (done) begin
			if (end_ctl.op == MODE_FREE) begin
				rsp_q.result_address <= '0;
				rsp_q.status         <= end_ctl.hit ? ST_OK : ST_UNKNOWN;
				rsp_q.reused         <= 1'b0;
			end else if (end_ctl.hit) begin
				rsp_q.result_address <= hit_payload[RES_W-1:0];
				rsp_q.status         <= ST_OK;
				rsp_q.reused         <= 1'b1;
			end else if (table_full) begin
				rsp_q.result_address <= '0;
				rsp_q.status         <= ST_TABLE_FULL;
				rsp_q.reused         <= 1'b0;
			end else if (!fits) begin
				rsp_q.result_address <= '0;
				rsp_q.status         <= ST_NOSPACE;
				rsp_q.reused         <= 1'b0;
			end else begin
				rsp_q.result_address <= app_payload[RES_W-1:0];
				rsp_q.status         <= ST_OK;
				rsp_q.reused         <= 1'b0;
			end
		end
	end

endmodule
